// File: sv/gwsc_pkg.sv
package gwsc_pkg;

    // field widths fixed by the interface
    localparam int CH_W       = 8;
    localparam int TOTAL_W    = 24;
    localparam int ROW_W      = 11;
    localparam int WORD_W     = 32;
    localparam int APB_DATA_W = 32;
    localparam int PADDR_W    = 3;

    // one line store entry holds the three previous rows of a column
    localparam int ROWS_BACK = 3;
    localparam int ENTRY_W   = ROWS_BACK * CH_W;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX       = '1;
    localparam logic [ROW_W-1:0]   ROW_WIDTH_RESET = ROW_W'(1024);
    localparam logic [WORD_W-1:0]  TARGET_RESET    = 32'h584D_4153;

    // register map, selected by paddr bit 2
    typedef enum logic {
        REG_ROW_WIDTH   = 1'b0,
        REG_TARGET_WORD = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic [ROW_W-1:0]  row_width;
        logic [WORD_W-1:0] target_word;
    } gwsc_cfg_t;

endpackage

// File: sv/gwsc_grid_if.sv
interface gwsc_grid_if import gwsc_pkg::*;;
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] ch;
    logic            last;

    modport source (output valid, output ch, output last, input ready);
    modport sink   (input valid, input ch, input last, output ready);
endinterface

// File: sv/gwsc_total_if.sv
interface gwsc_total_if import gwsc_pkg::*;;
    logic               valid;
    logic               ready;
    logic [TOTAL_W-1:0] match_total;

    modport source (output valid, output match_total, input ready);
    modport sink   (input valid, input match_total, output ready);
endinterface

// File: sv/gwsc_ram.sv
module gwsc_ram #(
    parameter int WIDTH  = 24,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr_a,
    output logic [WIDTH-1:0]  rd_data_a,
    input  logic [ADDR_W-1:0] rd_addr_b,
    output logic [WIDTH-1:0]  rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_a_reg;
    logic [WIDTH-1:0] rd_b_reg;

    // one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_a_reg <= mem[rd_addr_a];
        rd_b_reg <= mem[rd_addr_b];
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

// File: sv/gwsc_regs.sv
module gwsc_regs import gwsc_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_W-1:0]    paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output gwsc_cfg_t             cfg
);

    gwsc_cfg_t cfg_reg;
    reg_idx_t  sel_idx;
    logic      wr_stb;

    assign sel_idx = reg_idx_t'(paddr[PADDR_W-1]);
    assign wr_stb  = psel && penable && pwrite;
    assign pready  = 1'b1;

    // write on the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.row_width   <= ROW_WIDTH_RESET;
            cfg_reg.target_word <= TARGET_RESET;
        end
        else if (wr_stb)
        begin
            unique case (sel_idx)
                REG_ROW_WIDTH:   cfg_reg.row_width   <= pwdata[ROW_W-1:0];
                REG_TARGET_WORD: cfg_reg.target_word <= pwdata[WORD_W-1:0];
                default:         ;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        unique case (sel_idx)
            REG_ROW_WIDTH:   prdata = APB_DATA_W'(cfg_reg.row_width);
            REG_TARGET_WORD: prdata = APB_DATA_W'(cfg_reg.target_word);
            default:         prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

// File: sv/grid_word_search_counter.sv
// Channel   Dir   Payload                  Transaction
// grid      in    ch[7:0], last            one grid character, raster order
// result    out   match_total[23:0]        word count of a finished grid
// apb       in    row_width, target_word   register write / read
//
// One character per cycle: an input register feeds a single compute stage
// that reads four line store columns (c..c+3) from two dual-read RAMs.
// A character enters each cycle unless stalled; last registers the total.
// rst_n clears control state and the window; the line store is not cleared.
// Only a last character stalls, and only while a previous total waits.
module grid_word_search_counter import gwsc_pkg::*; #(
    parameter int MAX_ROW_WIDTH = 1024
) (
    input  logic                  clk,
    input  logic                  rst_n,
    gwsc_grid_if.sink             grid,
    gwsc_total_if.source          result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_W-1:0]    paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int CW   = $clog2(MAX_ROW_WIDTH);
    localparam int WW   = $clog2(MAX_ROW_WIDTH + 1);
    localparam int CMPW = (WW > ROW_W) ? WW : ROW_W;
    localparam int NRD  = 4;

    // four-cell line against the word, forward and reversed
    function automatic logic [1:0] line_hits(
        input logic [CH_W-1:0]   a0,
        input logic [CH_W-1:0]   a1,
        input logic [CH_W-1:0]   a2,
        input logic [CH_W-1:0]   a3,
        input logic [WORD_W-1:0] tw
    );
        logic fwd;
        logic rev;
        fwd = ({a0, a1, a2, a3} == tw);
        rev = ({a3, a2, a1, a0} == tw);
        return {1'b0, fwd} + {1'b0, rev};
    endfunction

    gwsc_cfg_t cfg;

    gwsc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // state
    logic                s1_valid_reg;
    logic [CH_W-1:0]     s1_ch_reg;
    logic                s1_last_reg;
    logic [CW-1:0]       col_reg;
    logic [1:0]          rows_reg;
    logic [CH_W-1:0]     win_reg [ROWS_BACK][4];
    logic [CH_W-1:0]     tail_reg [3];
    logic [TOTAL_W-1:0]  total_reg;
    logic                out_valid_reg;
    logic [TOTAL_W-1:0]  out_total_reg;
    logic [NRD-1:0]      byp_reg;
    logic [ENTRY_W-1:0]  byp_data_reg;

    logic [CW-1:0]       col_next;
    logic [1:0]          rows_next;
    logic [TOTAL_W-1:0]  total_next;
    logic                out_valid_next;
    logic [NRD-1:0]      byp_next;

    // effective row width
    logic [WW-1:0]       eff_w;
    logic [CMPW-1:0]     rw_ext;

    assign rw_ext = CMPW'(cfg.row_width);

    always_comb
    begin
        priority if (cfg.row_width == '0)
            eff_w = WW'(1);
        else if (rw_ext > CMPW'(MAX_ROW_WIDTH))
            eff_w = WW'(MAX_ROW_WIDTH);
        else
            eff_w = WW'(rw_ext);
    end

    // handshake
    logic proc;
    logic acc;

    assign proc         = s1_valid_reg && (!s1_last_reg || !out_valid_reg || result.ready);
    assign grid.ready   = !s1_valid_reg || proc;
    assign acc          = grid.valid && grid.ready;
    assign result.valid = out_valid_reg;
    assign result.match_total = out_total_reg;

    // column advance
    logic [WW-1:0] c_plus1;
    logic          row_wrap;
    logic [CW-1:0] col_after;
    logic [CW-1:0] col_item;

    assign c_plus1   = WW'(col_reg) + WW'(1);
    assign row_wrap  = (c_plus1 >= eff_w);
    assign col_after = row_wrap ? '0 : CW'(c_plus1);

    // column of the item that sits in the input register after this edge
    always_comb
    begin
        priority if (proc && s1_last_reg)
            col_item = '0;
        else if (proc)
            col_item = col_after;
        else
            col_item = col_reg;
    end

    // line store: read columns c..c+3, write column c
    logic [CW-1:0]      rd_addr [NRD];
    logic [ENTRY_W-1:0] rd_data [NRD];
    logic [ENTRY_W-1:0] ent [NRD];
    logic [ENTRY_W-1:0] new_entry;

    always_comb
    begin
        for (int k = 0; k < NRD; k++)
        begin
            rd_addr[k]  = col_item + CW'(k);
            byp_next[k] = proc && (rd_addr[k] == col_reg);
            ent[k]      = byp_reg[k] ? byp_data_reg : rd_data[k];
        end
    end

    assign new_entry = {ent[0][ENTRY_W-CH_W-1:0], s1_ch_reg};

    gwsc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_ROW_WIDTH)
    ) u_ram_lo (
        .clk       (clk),
        .wr_en     (proc),
        .wr_addr   (col_reg),
        .wr_data   (new_entry),
        .rd_addr_a (rd_addr[0]),
        .rd_data_a (rd_data[0]),
        .rd_addr_b (rd_addr[1]),
        .rd_data_b (rd_data[1])
    );

    gwsc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_ROW_WIDTH)
    ) u_ram_hi (
        .clk       (clk),
        .wr_en     (proc),
        .wr_addr   (col_reg),
        .wr_data   (new_entry),
        .rd_addr_a (rd_addr[2]),
        .rd_data_a (rd_data[2]),
        .rd_addr_b (rd_addr[3]),
        .rd_data_b (rd_data[3])
    );

    // line checks ending at the current cell
    logic          left_ok;
    logic          rows_ok;
    logic          right_ok;
    logic [1:0]    hit_hor;
    logic [1:0]    hit_ver;
    logic [1:0]    hit_dia;
    logic [1:0]    hit_ant;
    logic [3:0]    found;
    logic [TOTAL_W:0] sum;

    assign left_ok  = (col_reg >= CW'(3));
    assign rows_ok  = (rows_reg == 2'd3);
    assign right_ok = ((WW + 1)'(col_reg) + (WW + 1)'(3)) < (WW + 1)'(eff_w);

    assign hit_hor = line_hits(tail_reg[0], tail_reg[1], tail_reg[2], s1_ch_reg,
                               cfg.target_word);
    assign hit_ver = line_hits(ent[0][23:16], ent[0][15:8], ent[0][7:0], s1_ch_reg,
                               cfg.target_word);
    assign hit_dia = line_hits(win_reg[2][1], win_reg[1][2], win_reg[0][3], s1_ch_reg,
                               cfg.target_word);
    assign hit_ant = line_hits(ent[3][23:16], ent[2][15:8], ent[1][7:0], s1_ch_reg,
                               cfg.target_word);

    assign found = (left_ok ? 4'(hit_hor) : 4'd0)
                 + (rows_ok ? 4'(hit_ver) : 4'd0)
                 + ((rows_ok && left_ok) ? 4'(hit_dia) : 4'd0)
                 + ((rows_ok && right_ok) ? 4'(hit_ant) : 4'd0);

    // saturating running total
    assign sum = {1'b0, total_reg} + (TOTAL_W + 1)'(found);

    always_comb
    begin
        total_next = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
        rows_next  = (row_wrap && !rows_ok) ? rows_reg + 2'd1 : rows_reg;
        col_next   = col_after;
        out_valid_next = (out_valid_reg && !result.ready) || (proc && s1_last_reg);
    end

    // control and window state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s1_last_reg   <= 1'b0;
            col_reg       <= '0;
            rows_reg      <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
            byp_reg       <= '0;
            for (int k = 0; k < ROWS_BACK; k++)
            begin
                for (int j = 0; j < 4; j++)
                begin
                    win_reg[k][j] <= '0;
                end
            end
            for (int j = 0; j < 3; j++)
            begin
                tail_reg[j] <= '0;
            end
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            byp_reg       <= byp_next;
            if (grid.ready)
            begin
                s1_valid_reg <= grid.valid;
            end
            if (acc)
            begin
                s1_last_reg <= grid.last;
            end
            if (proc)
            begin
                if (s1_last_reg)
                begin
                    // grid done: start the next one clean
                    col_reg   <= '0;
                    rows_reg  <= '0;
                    total_reg <= '0;
                    for (int k = 0; k < ROWS_BACK; k++)
                    begin
                        for (int j = 0; j < 4; j++)
                        begin
                            win_reg[k][j] <= '0;
                        end
                    end
                    for (int j = 0; j < 3; j++)
                    begin
                        tail_reg[j] <= '0;
                    end
                end
                else
                begin
                    col_reg   <= col_next;
                    rows_reg  <= rows_next;
                    total_reg <= total_next;
                    for (int k = 0; k < ROWS_BACK; k++)
                    begin
                        for (int j = 0; j < 3; j++)
                        begin
                            win_reg[k][j] <= win_reg[k][j+1];
                        end
                        win_reg[k][3] <= ent[0][k*CH_W +: CH_W];
                    end
                    tail_reg[0] <= tail_reg[1];
                    tail_reg[1] <= tail_reg[2];
                    tail_reg[2] <= s1_ch_reg;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            s1_ch_reg <= grid.ch;
        end
        if (proc)
        begin
            byp_data_reg <= new_entry;
        end
        if (proc && s1_last_reg)
        begin
            out_total_reg <= total_next;
        end
    end

endmodule
